[src/rlw_pkg.sv]
// Shared types and constants for the rotated line-walk address generator.
// Used by every module of the block but rlw_fifo; depends on nothing.
`default_nettype none

package rlw_pkg;

  localparam int COORD_LIMIT = 8192;
  localparam int FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int LIM_W  = 16;  // holds COORD_LIMIT up to its top value
  localparam int DIST_W = 35;  // signed destination arithmetic
  localparam int SRC_W  = 14;
  localparam int DST_W  = 13;
  localparam int PROD_W = 33;

  localparam logic [SRC_W-1:0] SRC_MAX = 14'h3FFF;

  localparam logic [2:0] REG_ROT_ROWS   = 3'd0;
  localparam logic [2:0] REG_ROT_COLS   = 3'd1;
  localparam logic [2:0] REG_COL_OFFSET = 3'd2;
  localparam logic [2:0] REG_ROW_OFFSET = 3'd3;
  localparam logic [2:0] REG_STEP_X     = 3'd4;
  localparam logic [2:0] REG_STEP_Y     = 3'd5;
  localparam logic [2:0] REG_STEP_SRC   = 3'd6;
  localparam logic [2:0] REG_MODE       = 3'd7;

  localparam int MODE_HORIZ = 0;
  localparam int MODE_NEG   = 1;
  localparam int MODE_ABS   = 2;

  typedef struct packed {
    logic [13:0]        rot_rows;
    logic [13:0]        rot_cols;
    logic [13:0]        col_offset;
    logic [13:0]        row_offset;
    logic signed [17:0] step_x;
    logic signed [17:0] step_y;
    logic signed [18:0] step_src;
    logic [2:0]         mode;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0]       x_pos;
    logic signed [31:0]       y_pos;
    logic signed [PROD_W-1:0] prod;
    logic [SRC_W-1:0]         px;
  } entry_t;

  function automatic logic [SRC_W-1:0] sat_src(input logic signed [PROD_W:0] v);
    logic [SRC_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed((PROD_W+1)'(SRC_MAX))) begin
      r = SRC_MAX;
    end else begin
      r = v[SRC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic in_range(input logic signed [DIST_W-1:0] v,
                                    input logic [LIM_W-1:0] lim);
    logic r;
    r = (v >= 0) && (v < $signed(DIST_W'(lim)));
    return r;
  endfunction

endpackage

`default_nettype wire

[src/rotation_line_walk_address_gen_unit.sv]
// Rotated scan-line walk address generator, top level.
// Words pass the entry register, queue, copy registers and output register.
// Input words are taken one per cycle while the queue has room; the single
// output port issues one copy word per cycle while m_axis_tready allows it.
// Reset (rst, synchronous): accumulators zero, queue empty, registers to defaults.
`default_nettype none

module rotation_line_walk_address_gen_unit #(
  parameter int COORD_LIMIT = rlw_pkg::COORD_LIMIT,
  parameter int FRAC_BITS   = rlw_pkg::FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // line_index, line_start_x, src_index,
                                          // pixel_index, 7'b0
  input  wire logic        s_axis_tuser,  // first_of_line
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // src_row, src_col, dst_row, dst_col, 2'b0
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [18:0] cfg_data
);

  rlw_pkg::cfg_t   cfg;
  rlw_pkg::entry_t f_ent;
  rlw_pkg::entry_t q_ent;
  logic            f_valid, f_ready;
  logic            q_valid, q_ready;

  rlw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rlw_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_valid       (s_axis_tvalid),
    .s_ready       (s_axis_tready),
    .first_of_line (s_axis_tuser),
    .line_index    (s_axis_tdata[12:0]),
    .line_start_x  (s_axis_tdata[44:13]),
    .src_index     (s_axis_tdata[58:45]),
    .pixel_index   (s_axis_tdata[72:59]),
    .ent_valid     (f_valid),
    .ent_ready     (f_ready),
    .ent           (f_ent)
  );

  rlw_fifo #(
    .WIDTH ($bits(rlw_pkg::entry_t)),
    .DEPTH (rlw_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_ent),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_ent)
  );

  rlw_back #(
    .COORD_LIMIT (COORD_LIMIT),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .ent_valid     (q_valid),
    .ent_ready     (q_ready),
    .ent           (q_ent),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[src/rlw_cfg.sv]
// Configuration register file of the line-walk address generator.
// Depends on rlw_pkg for register indexes and the cfg_t bundle.
`default_nettype none

module rlw_cfg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [18:0]        cfg_data,
  output rlw_pkg::cfg_t           cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_rows   <= '0;
      cfg.rot_cols   <= '0;
      cfg.col_offset <= '0;
      cfg.row_offset <= '0;
      cfg.step_x     <= 18'sh10000;
      cfg.step_y     <= '0;
      cfg.step_src   <= 19'sh10000;
      cfg.mode       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rlw_pkg::REG_ROT_ROWS:   cfg.rot_rows   <= cfg_data[13:0];
        rlw_pkg::REG_ROT_COLS:   cfg.rot_cols   <= cfg_data[13:0];
        rlw_pkg::REG_COL_OFFSET: cfg.col_offset <= cfg_data[13:0];
        rlw_pkg::REG_ROW_OFFSET: cfg.row_offset <= cfg_data[13:0];
        rlw_pkg::REG_STEP_X:     cfg.step_x     <= cfg_data[17:0];
        rlw_pkg::REG_STEP_Y:     cfg.step_y     <= cfg_data[17:0];
        rlw_pkg::REG_STEP_SRC:   cfg.step_src   <= cfg_data;
        rlw_pkg::REG_MODE:       cfg.mode       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/rlw_front.sv]
// Front end: takes input words, runs the x/y accumulators and the source-line
// multiply, and registers one work entry. Depends on rlw_pkg.
`default_nettype none

module rlw_front #(
  parameter int FRAC_BITS = rlw_pkg::FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rlw_pkg::cfg_t      cfg,
  input  wire logic               s_valid,
  output logic                    s_ready,
  input  wire logic               first_of_line,
  input  wire logic [12:0]        line_index,
  input  wire logic signed [31:0] line_start_x,
  input  wire logic signed [13:0] src_index,
  input  wire logic [13:0]        pixel_index,
  output logic                    ent_valid,
  input  wire logic               ent_ready,
  output rlw_pkg::entry_t         ent
);

  logic [31:0] x_accum;
  logic [31:0] y_accum;
  logic [31:0] x_cur;
  logic [31:0] y_cur;
  logic [31:0] y_load;
  logic signed [rlw_pkg::PROD_W-1:0] prod;
  logic        accept;

  assign s_ready = !ent_valid || ent_ready;
  assign accept  = s_valid && s_ready;
  assign y_load  = 32'(line_index) << FRAC_BITS;
  assign x_cur   = first_of_line ? line_start_x : x_accum;
  assign y_cur   = first_of_line ? y_load : y_accum;
  assign prod    = src_index * cfg.step_src;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_accum   <= '0;
      y_accum   <= '0;
      ent_valid <= 1'b0;
    end else begin
      if (accept) begin
        x_accum   <= x_cur + 32'(cfg.step_x);
        y_accum   <= y_cur + 32'(cfg.step_y);
        ent.x_pos <= x_cur;
        ent.y_pos <= y_cur;
        ent.prod  <= prod;
        ent.px    <= pixel_index;
        ent_valid <= 1'b1;
      end else if (ent_ready) begin
        ent_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/rlw_fifo.sv]
// Small flip-flop queue between the front and back ends.
// Generic width and depth; no package dependencies.
`default_nettype none

module rlw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = count != FULL_CNT;
  assign out_valid = count != '0;
  assign out_data  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        mem[wptr] <= in_data;
        wptr      <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/rlw_back.sv]
// Back end: turns a work entry into destination addresses, bounds-checks both
// copies and issues those in range, one word per cycle while m_axis_tready
// allows, through an output register. Depends on rlw_pkg.
`default_nettype none

module rlw_back #(
  parameter int COORD_LIMIT = rlw_pkg::COORD_LIMIT,
  parameter int FRAC_BITS   = rlw_pkg::FRAC_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rlw_pkg::cfg_t    cfg,
  input  wire logic             ent_valid,
  output logic                  ent_ready,
  input  wire rlw_pkg::entry_t  ent,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [55:0]           m_axis_tdata,  // src_row, src_col, dst_row, dst_col, 2'b0
  output logic                  m_axis_tlast
);

  localparam int DW = rlw_pkg::DIST_W;
  localparam int LW = rlw_pkg::LIM_W;
  localparam int SW = rlw_pkg::SRC_W;
  localparam int TW = rlw_pkg::DST_W;
  localparam logic [LW-1:0] LIMIT = LW'(COORD_LIMIT);

  logic signed [31:0]                 x_fl;
  logic signed [31:0]                 y_fl;
  logic signed [rlw_pkg::PROD_W-1:0]  s_fl;
  logic signed [rlw_pkg::PROD_W:0]    s_wide;
  logic signed [rlw_pkg::PROD_W:0]    s_row;
  logic signed [DW-1:0] rows_s, cols_s, roff_s, coff_s;
  logic signed [DW-1:0] dr, dc, dr2, dc2;
  logic [LW-1:0]        lim_r, lim_c;
  logic                 horiz, neg, absm, row_shift;
  logic                 v1, v2;
  logic [SW-1:0]        sr_c, sc_c, s_sat, s_row_sat;

  logic          pend1, pend2;
  logic [SW-1:0] sr, sc;
  logic [TW-1:0] dr1_q, dc1_q, dr2_q, dc2_q;
  logic          out_take, a_free, a_load;

  assign horiz     = cfg.mode[rlw_pkg::MODE_HORIZ];
  assign neg       = cfg.mode[rlw_pkg::MODE_NEG];
  assign absm      = cfg.mode[rlw_pkg::MODE_ABS];
  assign row_shift = horiz || absm;

  assign x_fl   = ent.x_pos >>> FRAC_BITS;
  assign y_fl   = ent.y_pos >>> FRAC_BITS;
  assign s_fl   = ent.prod >>> FRAC_BITS;
  assign s_wide = (rlw_pkg::PROD_W+1)'(s_fl);
  assign s_row  = (absm && s_wide < 0) ? -s_wide : s_wide;

  assign rows_s = DW'(cfg.rot_rows);
  assign cols_s = DW'(cfg.rot_cols);
  assign roff_s = DW'(cfg.row_offset);
  assign coff_s = DW'(cfg.col_offset);

  always_comb begin
    if (neg) begin
      dr = rows_s - DW'(y_fl) - roff_s;
      dc = cols_s - DW'(x_fl) - coff_s;
    end else begin
      dr = DW'(y_fl) + roff_s;
      dc = DW'(x_fl) + coff_s;
    end
  end

  assign dr2 = row_shift ? dr + DW'(1) : dr;
  assign dc2 = row_shift ? dc : dc + DW'(1);

  assign lim_r = (LW'(cfg.rot_rows) < LIMIT) ? LW'(cfg.rot_rows) : LIMIT;
  assign lim_c = (LW'(cfg.rot_cols) < LIMIT) ? LW'(cfg.rot_cols) : LIMIT;

  assign v1 = rlw_pkg::in_range(dr, lim_r) && rlw_pkg::in_range(dc, lim_c);
  assign v2 = rlw_pkg::in_range(dr2, lim_r) && rlw_pkg::in_range(dc2, lim_c);

  assign s_sat     = rlw_pkg::sat_src(s_wide);
  assign s_row_sat = rlw_pkg::sat_src(s_row);
  assign sr_c      = row_shift ? s_row_sat : ent.px;
  assign sc_c      = row_shift ? ent.px : s_sat;

  assign out_take  = (pend1 || pend2) && (!m_axis_tvalid || m_axis_tready);
  assign a_free    = !(pend1 || pend2) || (out_take && !(pend1 && pend2));
  assign a_load    = ent_valid && a_free;
  assign ent_ready = a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend1         <= 1'b0;
      pend2         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (a_load) begin
        pend1 <= v1;
        pend2 <= v2;
        sr    <= sr_c;
        sc    <= sc_c;
        dr1_q <= dr[TW-1:0];
        dc1_q <= dc[TW-1:0];
        dr2_q <= dr2[TW-1:0];
        dc2_q <= dc2[TW-1:0];
      end else if (out_take) begin
        if (pend1) begin
          pend1 <= 1'b0;
        end else begin
          pend2 <= 1'b0;
        end
      end
      if (out_take) begin
        m_axis_tvalid <= 1'b1;
        if (pend1) begin
          m_axis_tdata <= {2'b00, dc1_q, dr1_q, sc, sr};
          m_axis_tlast <= !pend2;
        end else begin
          m_axis_tdata <= {2'b00, dc2_q, dr2_q, sc, sr};
          m_axis_tlast <= 1'b1;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
